FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset
`define GAC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gac assertion failed");

// Next-cycle implication, gated by reset
`define GAC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gac assertion failed");

`endif

FILE: hdl/gac_pkg.sv
// Package of the gamepad autofire controller: widths, register codes,
// reset values, the shot period table and the controller/datapath structs.
// No dependencies.
package gac_pkg;

	localparam int TimeW  = 32;
	localparam int BtnW   = 16;
	localparam int DpadW  = 4;
	localparam int RateW  = 6;
	localparam int StoreW = 8;
	localparam int DebW   = 8;
	localparam int PerW   = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_TURBO_MASK   = 3'd0,
		CFG_STORED_RATE  = 3'd1,
		CFG_DEFAULT_RATE = 3'd2,
		CFG_RATE_MIN     = 3'd3,
		CFG_RATE_MAX     = 3'd4,
		CFG_DEBOUNCE     = 3'd5
	} cfg_idx_t;

	// register reset values
	localparam logic [BtnW-1:0]   RstTurboMask  = 16'h3FFF;
	localparam logic [StoreW-1:0] RstStoredRate = 8'd15;
	localparam logic [RateW-1:0]  RstDefRate    = 6'd15;
	localparam logic [RateW-1:0]  RstRateMin    = 6'd5;
	localparam logic [RateW-1:0]  RstRateMax    = 6'd30;
	localparam logic [DebW-1:0]   RstDebounce   = 8'd5;
	localparam logic [RateW-1:0]  RstRate       = 6'd15;
	localparam logic [PerW-1:0]   RstPeriod     = 10'd66;

	// dpad codes and phase trims
	localparam logic [DpadW-1:0] DpadUp   = 4'd1;
	localparam logic [DpadW-1:0] DpadDown = 4'd2;
	localparam logic [TimeW-1:0] OnPhaseMs = 32'd3;
	localparam logic [TimeW-1:0] OffTrimMs = 32'd2;

	// 1000 / rate, rate zero treated as one
	localparam logic [PerW-1:0] PeriodMs [64] = '{
		10'd1000, 10'd1000, 10'd500, 10'd333, 10'd250, 10'd200, 10'd166, 10'd142,
		10'd125,  10'd111,  10'd100, 10'd90,  10'd83,  10'd76,  10'd71,  10'd66,
		10'd62,   10'd58,   10'd55,  10'd52,  10'd50,  10'd47,  10'd45,  10'd43,
		10'd41,   10'd40,   10'd38,  10'd37,  10'd35,  10'd34,  10'd33,  10'd32,
		10'd31,   10'd30,   10'd29,  10'd28,  10'd27,  10'd27,  10'd26,  10'd25,
		10'd25,   10'd24,   10'd23,  10'd23,  10'd22,  10'd22,  10'd21,  10'd21,
		10'd20,   10'd20,   10'd20,  10'd19,  10'd19,  10'd18,  10'd18,  10'd18,
		10'd17,   10'd17,   10'd17,  10'd16,  10'd16,  10'd16,  10'd16,  10'd15
	};

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic debounce;
		logic adjust;
		logic compare;
		logic phase;
		logic emit;
	} gac_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} gac_sts_t;

endpackage

FILE: hdl/gac_ctrl.sv
// Sequencer of the autofire controller: steps one poll through the datapath.
// Depends on gac_pkg.
module gac_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gac_pkg::gac_sts_t sts,
	output gac_pkg::gac_cmd_t cmd
);
	import gac_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DEB  = 6'b000010,
		ST_ADJ  = 6'b000100,
		ST_CMP  = 6'b001000,
		ST_PH   = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DEB;
			ST_DEB:  state_d = ST_ADJ;
			ST_ADJ:  state_d = ST_CMP;
			ST_CMP:  state_d = ST_PH;
			ST_PH:   state_d = ST_OUT;
			ST_OUT:  if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// decode commands
	assign in_stall     = (state_q != ST_IDLE);
	assign cmd.capture  = (state_q == ST_IDLE) && in_valid;
	assign cmd.debounce = (state_q == ST_DEB);
	assign cmd.adjust   = (state_q == ST_ADJ);
	assign cmd.compare  = (state_q == ST_CMP);
	assign cmd.phase    = (state_q == ST_PH);
	assign cmd.emit     = (state_q == ST_OUT) && sts.out_free;

endmodule

FILE: hdl/gac_dp.sv
// Datapath of the autofire controller: registers, debounce, toggle and rate
// step, phase timer and the output register. Depends on gac_pkg.
module gac_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gac_pkg::gac_cmd_t             cmd,
	output gac_pkg::gac_sts_t             sts,
	input  logic                          cfg_wr,
	input  logic [gac_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [gac_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [gac_pkg::TimeW-1:0]     now_ms,
	input  logic                          turbo_key,
	input  logic [gac_pkg::BtnW-1:0]      buttons_in,
	input  logic [gac_pkg::DpadW-1:0]     dpad_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gac_pkg::BtnW-1:0]      buttons_out,
	output logic [gac_pkg::DpadW-1:0]     dpad_out,
	output logic                          turbo_held,
	output logic                          led_on,
	output logic [gac_pkg::RateW-1:0]     shot_rate,
	output logic                          save_request
);
	import gac_pkg::*;

	// configuration
	logic [BtnW-1:0]   mask_q;
	logic [StoreW-1:0] stored_q;
	logic [RateW-1:0]  def_rate_q, rate_min_q, rate_max_q;
	logic [DebW-1:0]   deb_q;
	logic              reload_q;

	// captured poll and work values
	logic [TimeW-1:0]  now_q;
	logic              key_raw_q;
	logic [BtnW-1:0]   btn_q;
	logic [DpadW-1:0]  dpad_raw_q, dpad_q;
	logic              save_q;

	// persistent state
	logic              key_stable_q;
	logic [TimeW-1:0]  key_time_q;
	logic [BtnW-1:0]   prev_turbo_q, enable_q;
	logic [DpadW-1:0]  prev_dpad_q;
	logic [RateW-1:0]  rate_q;
	logic [PerW-1:0]   interval_q;
	logic [TimeW-1:0]  phase_start_q;
	logic              off_q, led_q, expired_q;

	// output register
	logic              out_valid_q;
	logic [BtnW-1:0]   out_btn_q;
	logic [DpadW-1:0]  out_dpad_q;
	logic              out_key_q, out_led_q, out_save_q;
	logic [RateW-1:0]  out_rate_q;

	// combinational helpers
	logic [RateW-1:0]  valid_rate;
	logic [TimeW-1:0]  key_elapsed, phase_elapsed;
	logic [BtnW-1:0]   turbo_now, btn_masked;
	logic              do_toggle, do_dpad, step_dn, step_up;
	logic [RateW-1:0]  rate_next;
	logic              off_next;

	assign sts.out_free = !out_valid_q || !out_stall;

	// validated stored rate
	always_comb begin
		if ((stored_q < {2'b00, rate_min_q}) || (stored_q > {2'b00, rate_max_q})) begin
			valid_rate = def_rate_q;
		end else begin
			valid_rate = stored_q[RateW-1:0];
		end
	end

	assign key_elapsed   = now_q - key_time_q;
	assign phase_elapsed = now_q - phase_start_q;

	// toggle and rate step decisions
	assign turbo_now = btn_q & mask_q;
	assign do_toggle = key_stable_q && (turbo_now != '0) && (turbo_now != prev_turbo_q);
	assign do_dpad   = key_stable_q && !do_toggle && (dpad_raw_q != '0)
	                   && (dpad_raw_q != prev_dpad_q);
	assign step_dn   = do_dpad && (dpad_raw_q == DpadDown) && (rate_min_q < rate_q);
	assign step_up   = do_dpad && (dpad_raw_q == DpadUp) && (rate_max_q > rate_q);

	always_comb begin
		rate_next = rate_q;
		priority if (step_dn) begin
			rate_next = rate_q - 6'd1;
		end else if (step_up) begin
			rate_next = rate_q + 6'd1;
		end
	end

	assign off_next   = !off_q;
	assign btn_masked = btn_q & ~enable_q;

	// configuration writes and stored rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= RstTurboMask;
			stored_q   <= RstStoredRate;
			def_rate_q <= RstDefRate;
			rate_min_q <= RstRateMin;
			rate_max_q <= RstRateMax;
			deb_q      <= RstDebounce;
			reload_q   <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_TURBO_MASK: mask_q <= cfg_data;
					CFG_STORED_RATE: begin
						stored_q <= cfg_data[StoreW-1:0];
						reload_q <= 1'b1;
					end
					CFG_DEFAULT_RATE: begin
						def_rate_q <= cfg_data[RateW-1:0];
						reload_q   <= 1'b1;
					end
					CFG_RATE_MIN: begin
						rate_min_q <= cfg_data[RateW-1:0];
						reload_q   <= 1'b1;
					end
					CFG_RATE_MAX: begin
						rate_max_q <= cfg_data[RateW-1:0];
						reload_q   <= 1'b1;
					end
					CFG_DEBOUNCE: deb_q <= cfg_data[DebW-1:0];
					default: ;
				endcase
			end else if (cmd.adjust && (step_dn || step_up)) begin
				stored_q <= {2'b00, rate_next};
			end
		end
	end

	// controller state: debounce, toggle, rate, phase timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_stable_q  <= 1'b0;
			key_time_q    <= '0;
			prev_turbo_q  <= '0;
			prev_dpad_q   <= '0;
			enable_q      <= '0;
			rate_q        <= RstRate;
			interval_q    <= RstPeriod;
			phase_start_q <= '0;
			off_q         <= 1'b0;
			led_q         <= 1'b0;
		end else begin
			// reload rate after a rate register write
			if (reload_q) begin
				rate_q     <= valid_rate;
				interval_q <= PeriodMs[valid_rate];
			end
			// flip the stable key once settled
			if (cmd.debounce && (key_raw_q != key_stable_q)
			    && (key_elapsed > {24'd0, deb_q})) begin
				key_stable_q <= !key_stable_q;
				key_time_q   <= now_q;
			end
			if (cmd.adjust) begin
				if (do_toggle) begin
					enable_q <= enable_q ^ turbo_now;
				end
				if (step_dn || step_up) begin
					rate_q     <= rate_next;
					interval_q <= PeriodMs[rate_next];
				end
				prev_turbo_q <= turbo_now;
				prev_dpad_q  <= dpad_raw_q;
			end
			// advance the on/off phase
			if (cmd.phase && expired_q) begin
				off_q <= off_next;
				if (off_next) begin
					phase_start_q <= phase_start_q + {22'd0, interval_q} - OffTrimMs;
					led_q         <= |(btn_masked & enable_q);
				end else begin
					phase_start_q <= phase_start_q + OnPhaseMs;
					led_q         <= |(btn_q & enable_q);
				end
			end
		end
	end

	// per-poll work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q      <= now_ms;
			key_raw_q  <= turbo_key;
			btn_q      <= buttons_in;
			dpad_raw_q <= dpad_in;
			dpad_q     <= dpad_in;
			save_q     <= 1'b0;
		end
		if (cmd.adjust) begin
			if (do_toggle) begin
				btn_q <= btn_q & ~mask_q;
			end
			if (do_dpad && ((dpad_raw_q == DpadDown) || (dpad_raw_q == DpadUp))) begin
				dpad_q <= '0;
			end
			save_q <= step_dn || step_up;
		end
		if (cmd.compare) begin
			expired_q <= !(phase_elapsed < {22'd0, interval_q});
		end
		// mask enabled buttons in an off phase
		if (cmd.phase && ((!expired_q && off_q) || (expired_q && off_next))) begin
			btn_q <= btn_masked;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_btn_q  <= btn_q;
			out_dpad_q <= dpad_q;
			out_key_q  <= key_stable_q;
			out_led_q  <= led_q;
			out_rate_q <= rate_q;
			out_save_q <= save_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign buttons_out  = out_btn_q;
	assign dpad_out     = out_dpad_q;
	assign turbo_held   = out_key_q;
	assign led_on       = out_led_q;
	assign shot_rate    = out_rate_q;
	assign save_request = out_save_q;

endmodule

FILE: hdl/gamepad_autofire_controller.sv
// Gamepad autofire controller: top level joining sequencer and datapath.
// Depends on gac_pkg, gac_ctrl and gac_dp.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one controller poll: now_ms,
//   turbo_key, buttons_in, dpad_in. A transfer happens when in_valid is high
//   and in_stall is low.
// - Output channel (out_valid/out_stall) returns one result per poll.
// - Config channel (cfg_valid/cfg_ready) writes register cfg_index with
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
// - Sequence: after the input transfer a poll runs through the five datapath
//   steps (debounce, toggle/rate step, phase compare, phase update, result
//   load); the result is loaded into the output register in the last step,
//   and no new input transfer is taken until it has been loaded.
// - Reset: configuration and state registers go to their defaults, shot rate 15,
//   phase interval 66 ms, all autofire enables off, no result pending.
// - A stalled result holds in the output register; the next finished poll
//   waits for it, and the input stays stalled meanwhile.
module gamepad_autofire_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gac_pkg::TimeW-1:0]     now_ms,
	input  logic                          turbo_key,
	input  logic [gac_pkg::BtnW-1:0]      buttons_in,
	input  logic [gac_pkg::DpadW-1:0]     dpad_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gac_pkg::BtnW-1:0]      buttons_out,
	output logic [gac_pkg::DpadW-1:0]     dpad_out,
	output logic                          turbo_held,
	output logic                          led_on,
	output logic [gac_pkg::RateW-1:0]     shot_rate,
	output logic                          save_request,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gac_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [gac_pkg::CfgDataW-1:0]  cfg_data
);
	import gac_pkg::*;

	gac_cmd_t cmd;
	gac_sts_t sts;

	assign cfg_ready = 1'b1;

	gac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gac_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.now_ms       (now_ms),
		.turbo_key    (turbo_key),
		.buttons_in   (buttons_in),
		.dpad_in      (dpad_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.buttons_out  (buttons_out),
		.dpad_out     (dpad_out),
		.turbo_held   (turbo_held),
		.led_on       (led_on),
		.shot_rate    (shot_rate),
		.save_request (save_request)
	);

endmodule

FILE: hdl/gac_checker.sv
// Port-level checker of the autofire controller and its bind.
// Depends on gac_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gac_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [gac_pkg::BtnW-1:0]      buttons_out,
	input logic [gac_pkg::DpadW-1:0]     dpad_out,
	input logic                          turbo_held,
	input logic                          save_request
);
	import gac_pkg::*;

	// a poll in work blocks the input for the next cycle
	`GAC_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
	// a rate change consumes the dpad
	`GAC_ASSERT_IMP(a_save_clears_dpad, out_valid && save_request, dpad_out == '0)
	// a rate change needs the turbo key held
	`GAC_ASSERT_IMP(a_save_needs_key, out_valid && save_request, turbo_held)
	// hold a stalled result
	`GAC_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(buttons_out) && $stable(dpad_out))

endmodule

bind gamepad_autofire_controller gac_checker u_gac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.buttons_out  (buttons_out),
	.dpad_out     (dpad_out),
	.turbo_held   (turbo_held),
	.save_request (save_request)
);
